[hw/rtl/ats_pkg.sv]
`default_nettype none

package ats_pkg;

    localparam int unsigned CharBits = 8;
    localparam int unsigned OutLineBits = 16;
    localparam int unsigned CfgBits = 16;
    localparam int unsigned ErrBits = 2;
    localparam int unsigned OutDataBits = 48;

    localparam logic [CharBits-1:0] ChEnd = 8'h00;
    localparam logic [CharBits-1:0] ChSemi = 8'h3B;
    localparam logic [CharBits-1:0] ChNewline = 8'h0A;
    localparam logic [CharBits-1:0] ChQuote = 8'h22;
    localparam logic [CharBits-1:0] ChBackslash = 8'h5C;
    localparam logic [CharBits-1:0] ChSpace = 8'h20;
    localparam logic [CharBits-1:0] ChTab = 8'h09;
    localparam logic [CharBits-1:0] ChCr = 8'h0D;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_WORD    = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_CLOSED  = 3'd4
    } t_mode;

    typedef enum logic [ErrBits-1:0] {
        ERR_NONE       = 2'd0,
        ERR_UNTERM     = 2'd1,
        ERR_UNEXPECTED = 2'd2
    } t_err;

    typedef struct packed {
        t_mode mode;
        logic  prev_bs;
        logic  quoted;
        t_err  err;
    } t_scan_ctl;

    typedef struct packed {
        logic in_token;
        logic token_first;
        logic token_done;
        logic end_of_text;
    } t_char_flags;

endpackage

`default_nettype wire

[hw/rtl/assembler_token_scanner_unit.sv]
// Channel   Dir  Handshake                  Payload
// s_axis    in   i_s_tvalid / o_s_tready    i_s_tdata: char_code
// m_axis    out  o_m_tvalid / i_m_tready    o_m_tdata: char echo, token flags, lines, error
// cfg       in   i_cfg_we (no wait)         i_cfg_wdata: first_line
//
// One character per cycle while the result side does not stall.
// The path from input request to result is the input register plus the result
// register; the step logic between them is a single small mode transition.
// Synchronous active-low reset: idle mode, no error, line count 1.
// A stalled result holds in the result register while the input register
// still takes one more request; a first_line write reloads the line count.
`default_nettype none

module assembler_token_scanner_unit import ats_pkg::*; #(
    parameter int unsigned LINE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [CharBits-1:0]    i_s_tdata,   // [7:0] char_code
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [7:0] char_echo, [8] in_token, [9] token_first, [10] token_done,
    // [11] is_string, [27:12] token_line, [43:28] line_now,
    // [45:44] error_code, [46] end_of_text, [47] zero
    output logic [OutDataBits-1:0]      o_m_tdata,
    input  wire logic                   i_cfg_we,
    input  wire logic [CfgBits-1:0]     i_cfg_wdata  // first_line
);

    localparam int unsigned ExtBits = LINE_BITS + OutLineBits;

    logic                    r_in_valid;
    logic [CharBits-1:0]     r_in_char;
    logic                    r_out_valid;
    logic [OutDataBits-1:0]  r_out_data;
    t_scan_ctl               r_ctl;
    logic [LINE_BITS-1:0]    r_line;
    logic [LINE_BITS-1:0]    r_start;

    t_scan_ctl               n_ctl;
    logic [LINE_BITS-1:0]    n_line;
    logic [LINE_BITS-1:0]    n_start;
    t_char_flags             step_flags;
    logic                    advance;
    logic [ExtBits-1:0]      line_ext;
    logic [ExtBits-1:0]      start_ext;
    logic [ExtBits-1:0]      cfg_ext;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign line_ext  = {{OutLineBits{1'b0}}, n_line};
    assign start_ext = {{OutLineBits{1'b0}}, n_start};
    assign cfg_ext   = {{LINE_BITS{1'b0}}, i_cfg_wdata};

    ats_step #(
        .LINE_BITS(LINE_BITS)
    ) u_step (
        .i_char  (r_in_char),
        .i_ctl   (r_ctl),
        .i_line  (r_line),
        .i_start (r_start),
        .o_ctl   (n_ctl),
        .o_line  (n_line),
        .o_start (n_start),
        .o_flags (step_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl       <= '{mode: MODE_IDLE, prev_bs: 1'b0, quoted: 1'b0, err: ERR_NONE};
            r_line      <= LINE_BITS'(1);
            r_start     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctl       <= n_ctl;
                r_start     <= n_start;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            // Register write reloads the counter at once
            if (i_cfg_we) begin
                r_line <= cfg_ext[LINE_BITS-1:0];
            end else if (advance) begin
                r_line <= n_line;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
        end
        if (advance) begin
            r_out_data <= {1'b0, step_flags.end_of_text, n_ctl.err,
                           line_ext[OutLineBits-1:0], start_ext[OutLineBits-1:0],
                           n_ctl.quoted, step_flags.token_done,
                           step_flags.token_first, step_flags.in_token, r_in_char};
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.err != ERR_NONE) |=> (r_ctl.err == $past(r_ctl.err)))
        else $error("scan error changed after being set");

    a_line_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cfg_we) |=> (r_line >= $past(r_line)))
        else $error("line count went backwards without a register write");

    a_first_in_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[9] || o_m_tdata[8]))
        else $error("token start outside a token");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_ctl.err != ERR_NONE) |=> (o_m_tdata[10:8] == 3'b000))
        else $error("token flags raised while in error");

endmodule

`default_nettype wire

[hw/rtl/ats_step.sv]
`default_nettype none

module ats_step import ats_pkg::*; #(
    parameter int unsigned LINE_BITS = 16
) (
    input  wire logic [CharBits-1:0]  i_char,
    input  wire t_scan_ctl            i_ctl,
    input  wire logic [LINE_BITS-1:0] i_line,
    input  wire logic [LINE_BITS-1:0] i_start,
    output t_scan_ctl                 o_ctl,
    output logic [LINE_BITS-1:0]      o_line,
    output logic [LINE_BITS-1:0]      o_start,
    output t_char_flags               o_flags
);

    logic is_end;
    logic is_blank;
    logic is_semi;
    logic is_nl;
    logic is_delim;
    logic idle_go;
    logic bump;
    logic starts;

    always_comb begin
        is_end   = (i_char == ChEnd);
        is_blank = (i_char == ChSpace) || (i_char inside {[ChTab:ChCr]});
        is_semi  = (i_char == ChSemi);
        is_nl    = (i_char == ChNewline);
        is_delim = is_end || is_blank || is_semi;

        o_ctl   = i_ctl;
        o_start = i_start;
        o_flags = '0;
        idle_go = 1'b0;
        bump    = 1'b0;
        starts  = 1'b0;

        if (i_ctl.err == ERR_NONE) begin
            case (i_ctl.mode)
                MODE_COMMENT: begin
                    if (is_nl) begin
                        bump = 1'b1;
                        o_ctl.mode = MODE_IDLE;
                    end else if (is_end) begin
                        o_ctl.mode = MODE_IDLE;
                    end
                end
                MODE_WORD: begin
                    if (is_delim) begin
                        o_flags.token_done = 1'b1;
                        idle_go = 1'b1;
                    end else begin
                        o_flags.in_token = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (is_end) begin
                        o_ctl.err  = ERR_UNTERM;
                        o_ctl.mode = MODE_IDLE;
                    end else if (i_char == ChQuote && !i_ctl.prev_bs) begin
                        o_flags.in_token = 1'b1;
                        o_ctl.mode = MODE_CLOSED;
                    end else begin
                        o_flags.in_token = 1'b1;
                        bump = is_nl;
                        o_ctl.prev_bs = (i_char == ChBackslash);
                    end
                end
                MODE_CLOSED: begin
                    if (is_delim) begin
                        o_flags.token_done = 1'b1;
                        idle_go = 1'b1;
                    end else begin
                        o_ctl.err  = ERR_UNEXPECTED;
                        o_ctl.mode = MODE_IDLE;
                    end
                end
                default: begin
                    idle_go = 1'b1;
                end
            endcase

            // Character seen between tokens: skip blanks, open a comment or start a token
            if (idle_go) begin
                o_ctl.mode = MODE_IDLE;
                if (is_end) begin
                    o_ctl.mode = MODE_IDLE;
                end else if (is_blank) begin
                    bump = is_nl;
                end else if (is_semi) begin
                    o_ctl.mode = MODE_COMMENT;
                end else begin
                    starts        = 1'b1;
                    o_start       = i_line;
                    o_ctl.quoted  = (i_char == ChQuote);
                    o_ctl.prev_bs = 1'b0;
                    o_ctl.mode    = (i_char == ChQuote) ? MODE_STRING : MODE_WORD;
                end
            end

            if (i_ctl.mode != MODE_WORD && i_ctl.mode != MODE_STRING
                    && i_ctl.mode != MODE_CLOSED && i_ctl.mode != MODE_COMMENT) begin
                o_flags.token_first = starts;
                o_flags.in_token    = starts;
            end

            if (is_end) begin
                o_ctl.prev_bs = 1'b0;
            end
        end

        // Saturate at all ones
        o_line = (bump && (i_line != '1)) ? i_line + 1'b1 : i_line;
        o_flags.end_of_text = is_end;
    end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ats_pkg::*;

    // Result fields from the top bit down to char_echo in the lowest byte.
    typedef struct packed {
        logic                   pad;
        logic                   eot;
        t_err                   err;
        logic [OutLineBits-1:0] line_now;
        logic [OutLineBits-1:0] tok_line;
        logic                   str;
        logic                   done;
        logic                   first;
        logic                   in_tok;
        logic [CharBits-1:0]    echo;
    } t_scan_result;

    class scan_scoreboard;
        t_mode                  mode;
        logic                   prev_bs;
        logic                   quoted;
        t_err                   err;
        logic [OutLineBits-1:0] line_cnt;
        logic [OutLineBits-1:0] tok_line;
        logic [CfgBits-1:0]     first_line;
        t_scan_result           expected_q[$];
        int unsigned            mismatches;

        function new();
            first_line = 1;
            line_cnt   = 1;
            tok_line   = '0;
            mode       = MODE_IDLE;
            prev_bs    = 1'b0;
            quoted     = 1'b0;
            err        = ERR_NONE;
            mismatches = 0;
        endfunction

        static function bit is_blank(logic [CharBits-1:0] c);
            return c == ChSpace || (c >= ChTab && c <= ChCr);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_first_line(logic [CfgBits-1:0] v);
            first_line = v;
            line_cnt   = v;
        endfunction

        function void bump_line();
            if (line_cnt != '1) begin
                line_cnt++;
            end
        endfunction

        // Character seen between tokens; returns 1 when it opens a token.
        function bit open_or_skip(logic [CharBits-1:0] c);
            if (c == ChEnd) begin
                return 1'b0;
            end
            if (is_blank(c)) begin
                if (c == ChNewline) begin
                    bump_line();
                end
                mode = MODE_IDLE;
                return 1'b0;
            end
            if (c == ChSemi) begin
                mode = MODE_COMMENT;
                return 1'b0;
            end
            tok_line = line_cnt;
            quoted   = (c == ChQuote);
            prev_bs  = 1'b0;
            mode     = quoted ? MODE_STRING : MODE_WORD;
            return 1'b1;
        endfunction

        function void note_char(logic [CharBits-1:0] c);
            t_scan_result want;
            bit fin;
            bit tok;
            bit first;
            bit done;
            bit ends_tok;
            fin      = (c == ChEnd);
            ends_tok = fin || is_blank(c) || c == ChSemi;
            tok      = 1'b0;
            first    = 1'b0;
            done     = 1'b0;
            if (err == ERR_NONE) begin
                case (mode)
                    MODE_COMMENT: begin
                        if (c == ChNewline) begin
                            bump_line();
                            mode = MODE_IDLE;
                        end else if (fin) begin
                            mode = MODE_IDLE;
                        end
                    end
                    MODE_WORD: begin
                        if (ends_tok) begin
                            done = 1'b1;
                            mode = MODE_IDLE;
                            void'(open_or_skip(c));
                        end else begin
                            tok = 1'b1;
                        end
                    end
                    MODE_STRING: begin
                        if (fin) begin
                            err  = ERR_UNTERM;
                            mode = MODE_IDLE;
                        end else if (c == ChQuote && !prev_bs) begin
                            tok  = 1'b1;
                            mode = MODE_CLOSED;
                        end else begin
                            tok = 1'b1;
                            if (c == ChNewline) begin
                                bump_line();
                            end
                            prev_bs = (c == ChBackslash);
                        end
                    end
                    MODE_CLOSED: begin
                        if (ends_tok) begin
                            done = 1'b1;
                            mode = MODE_IDLE;
                            void'(open_or_skip(c));
                        end else begin
                            err  = ERR_UNEXPECTED;
                            mode = MODE_IDLE;
                        end
                    end
                    default: begin
                        mode  = MODE_IDLE;
                        first = open_or_skip(c);
                        tok   = first;
                    end
                endcase
                if (fin) begin
                    prev_bs = 1'b0;
                end
            end
            want.pad      = 1'b0;
            want.eot      = fin;
            want.err      = err;
            want.line_now = line_cnt;
            want.tok_line = tok_line;
            want.str      = quoted;
            want.done     = done;
            want.first    = first;
            want.in_tok   = tok;
            want.echo     = c;
            expected_q.push_back(want);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        function void cmp(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                note_mismatch($sformatf("%s expected 0x%h got 0x%h", field, want, got));
            end
        endfunction

        function void check_result(logic [OutDataBits-1:0] data);
            t_scan_result got;
            t_scan_result want;
            got = data;
            if (expected_q.size() == 0) begin
                note_mismatch($sformatf("result 0x%h with no request outstanding", data));
                return;
            end
            want = expected_q.pop_front();
            cmp("char_echo", 16'(want.echo), 16'(got.echo));
            cmp("in_token", 16'(want.in_tok), 16'(got.in_tok));
            cmp("token_first", 16'(want.first), 16'(got.first));
            cmp("token_done", 16'(want.done), 16'(got.done));
            cmp("is_string", 16'(want.str), 16'(got.str));
            cmp("token_line", want.tok_line, got.tok_line);
            cmp("line_now", want.line_now, got.line_now);
            cmp("error_code", 16'(want.err), 16'(got.err));
            cmp("end_of_text", 16'(want.eot), 16'(got.eot));
            cmp("pad", 16'(want.pad), 16'(got.pad));
        endfunction

        function void flush_leftovers();
            while (expected_q.size() != 0) begin
                note_mismatch($sformatf("result for char 0x%h never came",
                                        expected_q[0].echo));
                void'(expected_q.pop_front());
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [CharBits-1:0]    i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OutDataBits-1:0] o_m_tdata;
    logic                   i_cfg_we;
    logic [CfgBits-1:0]     i_cfg_wdata;

    scan_scoreboard         sb = new();
    logic [CharBits-1:0]    text_q[$];
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     hold_req = 0;
    int                     hold_left = 0;

    assembler_token_scanner_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Check results before noting the request of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata);
            end
            if (i_s_tvalid && o_s_tready) begin
                sb.note_char(i_s_tdata);
            end
        end
    end

    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [CharBits-1:0] word_char();
        logic [CharBits-1:0] c;
        do begin
            c = CharBits'($urandom_range(1, 255));
        end while (scan_scoreboard::is_blank(c) || c == ChSemi);
        return c;
    endfunction

    function automatic void add_word();
        int len;
        logic [CharBits-1:0] c;
        len = $urandom_range(1, 8);
        do begin
            c = word_char();
        end while (c == ChQuote);
        text_q.push_back(c);
        repeat (len - 1) text_q.push_back(word_char());
    endfunction

    function automatic void add_string();
        int len;
        bit last_bs;
        logic [CharBits-1:0] c;
        logic [CharBits-1:0] picks[5];
        picks   = '{ChNewline, ChBackslash, ChQuote, 8'h01, 8'hFF};
        len     = $urandom_range(0, 10);
        last_bs = 1'b0;
        text_q.push_back(ChQuote);
        repeat (len) begin
            if ($urandom_range(99) < 30) begin
                c = picks[$urandom_range(4)];
            end else begin
                c = CharBits'($urandom_range(1, 255));
            end
            // escape a bare quote so it stays inside
            if (c == ChQuote && !last_bs) begin
                text_q.push_back(ChBackslash);
            end
            text_q.push_back(c);
            last_bs = (c == ChBackslash);
        end
        if (last_bs) begin
            text_q.push_back(8'h41);
        end
        text_q.push_back(ChQuote);
    endfunction

    function automatic void add_blanks();
        logic [CharBits-1:0] picks[6];
        picks = '{ChSpace, ChTab, ChNewline, 8'h0B, 8'h0C, ChCr};
        repeat ($urandom_range(1, 3)) text_q.push_back(picks[$urandom_range(5)]);
    endfunction

    function automatic void add_comment(bit closed);
        logic [CharBits-1:0] c;
        text_q.push_back(ChSemi);
        repeat ($urandom_range(0, 6)) begin
            do begin
                c = CharBits'($urandom_range(1, 255));
            end while (c == ChNewline);
            text_q.push_back(c);
        end
        if (closed) begin
            text_q.push_back(ChNewline);
        end
    endfunction

    function automatic void add_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            add_blanks();
        end else if (pick < 85) begin
            add_comment(1'b1);
        end else begin
            add_blanks();
            add_comment(1'b1);
        end
    endfunction

    // Well-formed text, or noise with no quotes; both finish with end of text.
    function automatic void build_text();
        int ntok;
        logic [CharBits-1:0] c;
        text_q.delete();
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(3, 12)) begin
                c = CharBits'($urandom_range(0, 255));
                text_q.push_back(c == ChQuote ? 8'h21 : c);
            end
        end else begin
            ntok = $urandom_range(1, 6);
            if ($urandom_range(1)) begin
                add_gap();
            end
            for (int k = 0; k < ntok; k++) begin
                if ($urandom_range(99) < 40) begin
                    add_string();
                end else begin
                    add_word();
                end
                if (k != ntok - 1 || $urandom_range(1)) begin
                    add_gap();
                end
            end
            if ($urandom_range(99) < 20) begin
                add_comment(1'b0);
            end
        end
        text_q.push_back(ChEnd);
    endfunction

    // Entered and left at a falling edge; valid stays high for the next request.
    task automatic send_char(input logic [CharBits-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_q[k]) begin
            send_char(text_q[k]);
        end
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0 && waited < 50000) begin
            @(negedge i_clk);
            waited++;
        end
    endtask

    task automatic write_first_line(input logic [CfgBits-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        sb.set_first_line(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int sent;
        logic [CfgBits-1:0] cfg_val;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: byte extremes, every blank, comment, escaped quote,
        // newline in a string, empty string, end after each kind of token
        text_q = '{ChSpace, 8'h01, 8'hFF, ChSemi, 8'h63, ChQuote, ChNewline,
                   ChTab, ChQuote, 8'h61, ChBackslash, ChQuote, ChNewline, ChQuote,
                   ChCr, 8'h80, 8'h7F, 8'h0B, 8'h0C, ChQuote, ChQuote, ChEnd,
                   8'h41, ChEnd, ChSemi, ChEnd, ChEnd};
        send_text();
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       cfg_val = 16'hFFFE;
                1:       cfg_val = 16'h0000;
                2:       cfg_val = 16'hFFFF;
                4:       cfg_val = 16'h0001;
                default: cfg_val = CfgBits'($urandom_range(0, 65535));
            endcase
            write_first_line(cfg_val);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (phase == 4) begin
                // hold the result side off while requests keep coming
                @(posedge i_clk);
                hold_req = 300;
                @(negedge i_clk);
            end
            sent = 0;
            while (sent < 45) begin
                build_text();
                sent += text_q.size();
                send_text();
            end
            drain();
        end

        // one sticky error, then check that state and token flags stay frozen after it
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        if ($urandom_range(1) == 0) begin
            text_q = '{8'h61, ChSpace, ChQuote, 8'h78, ChNewline, ChEnd};
        end else begin
            text_q = '{ChQuote, 8'h71, ChQuote, 8'h7A};
        end
        repeat (24) text_q.push_back(CharBits'($urandom_range(0, 255)));
        text_q.push_back(ChNewline);
        text_q.push_back(ChEnd);
        send_text();

        drain();
        repeat (8) @(negedge i_clk);
        sb.flush_leftovers();
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
